// File: rtl/core/intdiv64_pkg.sv
// intdiv64_pkg: word types for the 64-bit integer divider.
// Depends on nothing; imported by integer_divider_64_unit and testbench.
`timescale 1ns / 1ps

package intdiv64_pkg;

    // Width of every data field on the ports
    localparam int FIELD_WIDTH = 64;

    // Operation codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // Input word: mode, dividend and divisor
    typedef struct packed {
        logic                   op;
        logic [FIELD_WIDTH-1:0] dividend;
        logic [FIELD_WIDTH-1:0] divisor;
    } div_req_t;

    // Result word: quotient, remainder and zero-divisor flag
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder_out;
        logic                   divide_by_zero;
    } div_rsp_t;

endpackage

// File: rtl/core/integer_divider_64_unit.sv
// integer_divider_64_unit: pipelined signed/unsigned integer divider.
// Depends on intdiv64_pkg (word types and op codes).
`timescale 1ns / 1ps
//
// Channel   Ports                    Direction  Handshake
// --------  -----------------------  ---------  --------------------------------
// operands  start, busy, operands    in         taken when start && !busy
// result    done, result             out        one-cycle strobe, no back-pressure
//
// Stage 0 registers the magnitudes, then one restoring subtract-and-compare
// stage per quotient bit follows, and the output register takes the sign fix.
// A new word enters every cycle; busy never rises.
// Reset clears only the valid bits that travel down the pipeline and the done strobe.

module integer_divider_64_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  intdiv64_pkg::div_req_t operands,
    output logic                   done,
    output intdiv64_pkg::div_rsp_t result
);
    import intdiv64_pkg::*;

    localparam int W = DATA_WIDTH;

    // Input side signals
    logic         in_take;
    logic [W-1:0] a_in;
    logic [W-1:0] b_in;
    logic         a_neg_in;
    logic         b_neg_in;
    logic [W-1:0] am_in;
    logic [W-1:0] bm_in;

    // Pipeline stage registers; stage 0 holds magnitudes, stage W the final step
    logic         valid_reg [0:W];
    logic [W-1:0] rem_reg   [0:W];
    logic [W-1:0] quo_reg   [0:W];
    logic [W-1:0] den_reg   [0:W];
    logic         negq_reg  [0:W];
    logic         negr_reg  [0:W];
    logic         dz_reg    [0:W];

    // Output register
    logic     done_reg;
    div_rsp_t result_reg;
    div_rsp_t result_next;

    // Accept every cycle
    assign busy    = 1'b0;
    assign in_take = start && !busy;

    // Take magnitudes of the used low bits
    always_comb
    begin
        a_in     = operands.dividend[W-1:0];
        b_in     = operands.divisor[W-1:0];
        a_neg_in = (operands.op == OP_SIGNED) && a_in[W-1];
        b_neg_in = (operands.op == OP_SIGNED) && b_in[W-1];
        am_in    = a_neg_in ? (~a_in + W'(1)) : a_in;
        bm_in    = b_neg_in ? (~b_in + W'(1)) : b_in;
    end

    // Stage 0 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_take;
        end
    end

    // Stage 0 payload: remainder starts at zero, dividend sits in the quotient slot
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= am_in;
            den_reg[0]  <= bm_in;
            negq_reg[0] <= a_neg_in ^ b_neg_in;
            negr_reg[0] <= a_neg_in;
            dz_reg[0]   <= (b_in == '0);
        end
    end

    // One restoring step per stage: shift in a dividend bit, subtract if it fits
    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [W:0]   trial;
        logic [W+1:0] diff;
        logic         fits;
        logic [W-1:0] rem_next;
        logic [W-1:0] quo_next;

        always_comb
        begin
            trial    = {rem_reg[k], quo_reg[k][W-1]};
            diff     = {1'b0, trial} - {2'b00, den_reg[k]};
            fits     = !diff[W+1];
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[k][W-2:0], fits};
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (valid_reg[k])
            begin
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
                den_reg[k+1]  <= den_reg[k];
                negq_reg[k+1] <= negq_reg[k];
                negr_reg[k+1] <= negr_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
            end
        end
    end

    // Fix signs; a zero divisor forces an all-ones quotient, and the remainder
    // already equals the dividend magnitude, so the usual sign fix restores it
    always_comb
    begin
        logic [W-1:0] q_fix;
        logic [W-1:0] r_fix;
        q_fix = negq_reg[W] ? (~quo_reg[W] + W'(1)) : quo_reg[W];
        r_fix = negr_reg[W] ? (~rem_reg[W] + W'(1)) : rem_reg[W];
        if (dz_reg[W])
        begin
            q_fix = '1;
        end
        result_next.quotient       = FIELD_WIDTH'(q_fix);
        result_next.remainder_out  = FIELD_WIDTH'(r_fix);
        result_next.divide_by_zero = dz_reg[W];
    end

    // Output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[W];
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (valid_reg[W])
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for integer_divider_64_unit, signed and unsigned.
// Depends on intdiv64_pkg and integer_divider_64_unit; predicts each word in place.
`timescale 1ns / 1ps

module testbench;
    import intdiv64_pkg::*;

    localparam int          LATENCY  = 64 + 2;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    div_req_t operands;
    logic     done;
    div_rsp_t result;

    div_rsp_t pending_results[$];
    int       error_count;
    bit       start_is_high;

    integer_divider_64_unit #(
        .DATA_WIDTH(64)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .result  (result)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Compute quotient, remainder and zero flag for one operand word
    function automatic div_rsp_t predict_division(input div_req_t req);
        div_rsp_t    rsp;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] quo;
        logic [63:0] rem;
        logic        neg_a;
        logic        neg_b;
        rsp.divide_by_zero = 1'b0;
        if (req.divisor == '0)
        begin
            rsp.quotient       = ALL_ONES;
            rsp.remainder_out  = req.dividend;
            rsp.divide_by_zero = 1'b1;
        end
        else if (req.op == OP_UNSIGNED)
        begin
            rsp.quotient      = req.dividend / req.divisor;
            rsp.remainder_out = req.dividend % req.divisor;
        end
        else
        begin
            // Divide magnitudes; the most negative value keeps its pattern as 2^63
            neg_a = req.dividend[63];
            neg_b = req.divisor[63];
            mag_a = neg_a ? (~req.dividend + 64'd1) : req.dividend;
            mag_b = neg_b ? (~req.divisor + 64'd1) : req.divisor;
            quo   = mag_a / mag_b;
            rem   = mag_a % mag_b;
            if (neg_a != neg_b)
                quo = ~quo + 64'd1;
            if (neg_a)
                rem = ~rem + 64'd1;
            rsp.quotient      = quo;
            rsp.remainder_out = rem;
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        div_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", result.quotient, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.quotient !== want.quotient)
                    report_mismatch("quotient", result.quotient, want.quotient);
                if (result.remainder_out !== want.remainder_out)
                    report_mismatch("remainder_out", result.remainder_out,
                                    want.remainder_out);
                if (result.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", {63'd0, result.divide_by_zero},
                                    {63'd0, want.divide_by_zero});
            end
        end
    end

    // Send one word, after an idle gap if one is asked for; hold start high across back-to-back words
    task automatic send_word(input logic op, input logic [63:0] dividend,
                             input logic [63:0] divisor, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            start_is_high = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        if (!start_is_high)
            start <= 1'b1;
        start_is_high = 1'b1;
        operands <= '{op: op, dividend: dividend, divisor: divisor};
        // Wait for the accepting edge
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_division(operands));
    endtask

    task automatic send_random_gap(input logic op, input logic [63:0] dividend,
                                   input logic [63:0] divisor);
        send_word(op, dividend, divisor, $urandom_range(0, 8));
    endtask

    // Drop start and hold off until every expected word is back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        start_is_high = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Draw one operand from a mix of shapes
    function automatic logic [63:0] random_operand();
        logic [63:0] val;
        case ($urandom_range(0, 6))
            0, 1: val = {$urandom, $urandom};
            2: val = 64'($urandom_range(0, 255));
            3: val = ~64'($urandom_range(0, 255)) + 64'd1;
            4: val = {$urandom, $urandom} >> $urandom_range(1, 63);
            5: val = ~({$urandom, $urandom} >> $urandom_range(1, 63));
            default:
            begin
                case ($urandom_range(0, 5))
                    0: val = '0;
                    1: val = 64'd1;
                    2: val = ALL_ONES;
                    3: val = MOST_NEG;
                    4: val = MOST_POS;
                    default: val = MOST_NEG + 64'd1;
                endcase
            end
        endcase
        return val;
    endfunction

    task automatic test_zero_divisor();
        send_random_gap(OP_UNSIGNED, 64'h0123_4567_89AB_CDEF, '0);
        send_random_gap(OP_SIGNED, 64'hFEDC_BA98_7654_3210, '0);
        send_random_gap(OP_UNSIGNED, '0, '0);
        send_random_gap(OP_SIGNED, MOST_NEG, '0);
        drain_results();
    endtask

    task automatic test_signed_overflow();
        send_random_gap(OP_SIGNED, MOST_NEG, ALL_ONES);
        send_random_gap(OP_UNSIGNED, MOST_NEG, ALL_ONES);
        send_random_gap(OP_SIGNED, MOST_NEG, 64'd1);
        send_random_gap(OP_SIGNED, MOST_NEG, MOST_NEG);
        drain_results();
    endtask

    task automatic test_operand_extremes();
        send_random_gap(OP_UNSIGNED, ALL_ONES, 64'd1);
        send_random_gap(OP_UNSIGNED, ALL_ONES, ALL_ONES);
        send_random_gap(OP_UNSIGNED, '0, ALL_ONES);
        send_random_gap(OP_UNSIGNED, 64'd1, ALL_ONES);
        send_random_gap(OP_UNSIGNED, ALL_ONES, 64'd2);
        send_random_gap(OP_SIGNED, MOST_POS, MOST_NEG);
        send_random_gap(OP_SIGNED, MOST_NEG, MOST_POS);
        drain_results();
    endtask

    task automatic test_sign_combinations();
        send_random_gap(OP_SIGNED, 64'd7, 64'd2);
        send_random_gap(OP_SIGNED, -64'sd7, 64'd2);
        send_random_gap(OP_SIGNED, 64'd7, -64'sd2);
        send_random_gap(OP_SIGNED, -64'sd7, -64'sd2);
        send_random_gap(OP_SIGNED, -64'sd3, 64'd5);
        send_random_gap(OP_SIGNED, ALL_ONES, MOST_POS);
        drain_results();
    endtask

    // Random mix of modes and operand shapes, with bursts and idle gaps
    task automatic test_random_traffic(input int count);
        logic [63:0] divisor;
        int          gap;
        bit          burst;
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (i == count / 2)
                drain_results();
            divisor = ($urandom_range(0, 39) == 0) ? '0 : random_operand();
            gap     = burst ? 0 : $urandom_range(0, 8);
            send_word(1'($urandom), random_operand(), divisor, gap);
        end
        drain_results();
    endtask

    initial
    begin
        error_count   = 0;
        start_is_high = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        operands      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_divisor();
        test_signed_overflow();
        test_operand_extremes();
        test_sign_combinations();
        test_random_traffic(1600);

        // Let any stray word surface
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
